// ----- design/rhc_pkg.sv -----
package rhc_pkg;

    // Fraction bits of the hue and saturation results.
    localparam int HUE_FRAC_BITS = 6;
    localparam int SAT_FRAC_BITS = 12;

    // Field widths.
    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    localparam int SAT_W = 13;

    // The sector-adjusted hue numerator stays below 6 * 255, so it fits 11 bits.
    localparam int SCALED_W = 11;

    // 60 degrees expressed in hue units.
    localparam int HUE_SCALE   = 60 << HUE_FRAC_BITS;
    localparam int HUE_SCALE_W = 6 + HUE_FRAC_BITS;

    // Dividend widths of the two divisions.
    localparam int HUE_NUM_W = SCALED_W + HUE_SCALE_W;
    localparam int SAT_NUM_W = CH_W + SAT_FRAC_BITS;

    // Dividend bits above the quotient, compared against the divisor to
    // detect a quotient that does not fit its field.
    localparam int HUE_HI_W  = HUE_NUM_W - HUE_W;
    localparam int SAT_HI_W  = SAT_NUM_W - SAT_W;
    localparam int HUE_CMP_W = (HUE_HI_W > CH_W) ? HUE_HI_W : CH_W;
    localparam int SAT_CMP_W = (SAT_HI_W > CH_W) ? SAT_HI_W : CH_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    // One stage of the two shift-subtract dividers. The num fields start as
    // the low dividend bits and fill up with quotient bits from the bottom.
    typedef struct packed {
        logic [CH_W-1:0]  h_div;
        logic [CH_W-1:0]  h_rem;
        logic [HUE_W-1:0] h_num;
        logic             h_zero;
        logic             h_ovf;
        logic [CH_W-1:0]  s_rem;
        logic [SAT_W-1:0] s_num;
        logic             s_zero;
        logic             s_ovf;
        logic [CH_W-1:0]  value;
    } div_t;

endpackage

// ----- design/rgb_to_hsv_convert_unit.sv -----
// RGB to HSV conversion, one pixel word per clock while the output is not stalled.
//
// The input channel (s_valid, s_ready, s_data) takes one 8-bit RGB pixel per
// word. The result channel (m_valid, m_ready, m_data) returns hue in 1/64
// degree units, saturation in 1/4096 units and brightness equal to the
// largest channel. Words leave in the order they arrive, one result per pixel.
//
// The pipeline has 19 register stages: channel max/min, sector offset,
// hue scaling multiply, divider setup, and fifteen shift-subtract steps that
// each retire one quotient bit of the hue and, in the last thirteen, one bit
// of the saturation. A new pixel can be accepted every cycle while the output
// is not stalled.
//
// Each stage carries its own valid bit and moves forward whenever the stage
// after it is empty or moving, so a stall on m_ready fills empty stages first
// and s_ready drops only when every stage holds a word. Nothing is dropped or
// repeated during a stall.
//
// Reset (aresetn low at a clock edge) empties the pipeline; data in flight is
// discarded. There is no configuration.
module rgb_to_hsv_convert_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rhc_pkg::pixel_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rhc_pkg::hsv_t m_data
);

    // Stage map: 0 max/min, 1 sector offset, 2 multiply, 3 divider setup,
    // 4 onward one divide step each.
    localparam int FRONT_STAGES = 4;
    localparam int NUM_STAGES   = FRONT_STAGES + rhc_pkg::HUE_W;
    localparam int SAT_START    = rhc_pkg::HUE_W - rhc_pkg::SAT_W;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    // One restoring division step on an 8-bit divisor: returns the quotient
    // bit on top of the new remainder.
    function automatic logic [rhc_pkg::CH_W:0] div_bit(
        input logic [rhc_pkg::CH_W-1:0] rem,
        input logic                     num_bit,
        input logic [rhc_pkg::CH_W-1:0] divisor
    );
        logic [rhc_pkg::CH_W:0] trial;
        logic [rhc_pkg::CH_W:0] diff;
        trial = {rem, num_bit};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            div_bit = {1'b1, diff[rhc_pkg::CH_W-1:0]};
        end else begin
            div_bit = {1'b0, trial[rhc_pkg::CH_W-1:0]};
        end
    endfunction

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] stage_en;

    // Handshake and stage advance. A stage loads when it is empty or when the
    // stage after it is loading too.
    always_comb begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: largest and smallest channel, the sector with red winning
    // ties over green and green over blue, and the in-sector difference.
    logic [rhc_pkg::CH_W-1:0] a_mx_reg, a_mx_next;
    logic [rhc_pkg::CH_W-1:0] a_d_reg, a_d_next;
    sector_t                  a_sector_reg, a_sector_next;
    logic signed [rhc_pkg::CH_W:0] a_diff_reg, a_diff_next;
    logic [rhc_pkg::CH_W-1:0] a_mn;

    always_comb begin
        a_mx_next = s_data.red;
        a_mn      = s_data.red;
        if (s_data.green > a_mx_next) a_mx_next = s_data.green;
        if (s_data.blue > a_mx_next) a_mx_next = s_data.blue;
        if (s_data.green < a_mn) a_mn = s_data.green;
        if (s_data.blue < a_mn) a_mn = s_data.blue;
        a_d_next = a_mx_next - a_mn;

        priority if (s_data.red >= s_data.green && s_data.red >= s_data.blue) begin
            a_sector_next = SECTOR_RED;
            a_diff_next   = $signed({1'b0, s_data.green}) - $signed({1'b0, s_data.blue});
        end else if (s_data.green >= s_data.blue) begin
            a_sector_next = SECTOR_GREEN;
            a_diff_next   = $signed({1'b0, s_data.blue}) - $signed({1'b0, s_data.red});
        end else begin
            a_sector_next = SECTOR_BLUE;
            a_diff_next   = $signed({1'b0, s_data.red}) - $signed({1'b0, s_data.green});
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            a_mx_reg     <= a_mx_next;
            a_d_reg      <= a_d_next;
            a_sector_reg <= a_sector_next;
            a_diff_reg   <= a_diff_next;
        end
    end

    // Stage 1: add the sector offset (0, 2d or 4d) and wrap a negative hue
    // by a full turn of 6d.
    logic [rhc_pkg::CH_W-1:0]     b_mx_reg;
    logic [rhc_pkg::CH_W-1:0]     b_d_reg;
    logic [rhc_pkg::SCALED_W-1:0] b_scaled_reg, b_scaled_next;
    logic [rhc_pkg::SCALED_W-1:0] b_base;
    logic [rhc_pkg::SCALED_W-1:0] b_six_d;
    logic signed [rhc_pkg::SCALED_W+1:0] b_sum;
    logic signed [rhc_pkg::SCALED_W+1:0] b_wrapped;

    always_comb begin
        unique case (a_sector_reg)
            SECTOR_RED:   b_base = '0;
            SECTOR_GREEN: b_base = rhc_pkg::SCALED_W'({a_d_reg, 1'b0});
            SECTOR_BLUE:  b_base = rhc_pkg::SCALED_W'({a_d_reg, 2'b00});
            default:      b_base = '0;
        endcase
        b_six_d = rhc_pkg::SCALED_W'({a_d_reg, 2'b00}) + rhc_pkg::SCALED_W'({a_d_reg, 1'b0});
        b_sum   = $signed({2'b00, b_base}) + (rhc_pkg::SCALED_W + 2)'(a_diff_reg);
        if (b_sum < 0) begin
            b_wrapped = b_sum + $signed({2'b00, b_six_d});
        end else begin
            b_wrapped = b_sum;
        end
        b_scaled_next = b_wrapped[rhc_pkg::SCALED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            b_mx_reg     <= a_mx_reg;
            b_d_reg      <= a_d_reg;
            b_scaled_reg <= b_scaled_next;
        end
    end

    // Stage 2: form both dividends.
    logic [rhc_pkg::CH_W-1:0]      c_mx_reg;
    logic [rhc_pkg::CH_W-1:0]      c_d_reg;
    logic [rhc_pkg::HUE_NUM_W-1:0] c_hue_num_reg, c_hue_num_next;
    logic [rhc_pkg::SAT_NUM_W-1:0] c_sat_num_reg, c_sat_num_next;

    assign c_hue_num_next = rhc_pkg::HUE_NUM_W'(b_scaled_reg)
                          * rhc_pkg::HUE_NUM_W'(rhc_pkg::HUE_SCALE);
    assign c_sat_num_next = rhc_pkg::SAT_NUM_W'(b_d_reg) << rhc_pkg::SAT_FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            c_mx_reg      <= b_mx_reg;
            c_d_reg       <= b_d_reg;
            c_hue_num_reg <= c_hue_num_next;
            c_sat_num_reg <= c_sat_num_next;
        end
    end

    // Stage 3: divider setup. The dividend bits above the quotient width are
    // the starting remainder; if they already reach the divisor the quotient
    // would not fit and the result saturates to all ones.
    rhc_pkg::div_t div_reg [0:rhc_pkg::HUE_W];
    rhc_pkg::div_t div_init_next;
    logic [rhc_pkg::HUE_CMP_W-1:0] d_hue_hi;
    logic [rhc_pkg::SAT_CMP_W-1:0] d_sat_hi;

    always_comb begin
        d_hue_hi = rhc_pkg::HUE_CMP_W'(c_hue_num_reg[rhc_pkg::HUE_NUM_W-1:rhc_pkg::HUE_W]);
        d_sat_hi = rhc_pkg::SAT_CMP_W'(c_sat_num_reg[rhc_pkg::SAT_NUM_W-1:rhc_pkg::SAT_W]);

        div_init_next.h_div  = c_d_reg;
        div_init_next.h_rem  = d_hue_hi[rhc_pkg::CH_W-1:0];
        div_init_next.h_num  = c_hue_num_reg[rhc_pkg::HUE_W-1:0];
        div_init_next.h_zero = (c_d_reg == '0);
        div_init_next.h_ovf  = (d_hue_hi >= rhc_pkg::HUE_CMP_W'(c_d_reg));
        div_init_next.s_rem  = d_sat_hi[rhc_pkg::CH_W-1:0];
        div_init_next.s_num  = c_sat_num_reg[rhc_pkg::SAT_W-1:0];
        div_init_next.s_zero = (c_mx_reg == '0);
        div_init_next.s_ovf  = (d_sat_hi >= rhc_pkg::SAT_CMP_W'(c_mx_reg));
        div_init_next.value  = c_mx_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[FRONT_STAGES-1]) begin
            div_reg[0] <= div_init_next;
        end
    end

    // Divide steps. Every step retires one hue quotient bit; the saturation
    // quotient is shorter and starts late so both finish together.
    for (genvar i = 1; i <= rhc_pkg::HUE_W; i++) begin : g_div
        rhc_pkg::div_t          div_next;
        logic [rhc_pkg::CH_W:0] h_res;
        logic [rhc_pkg::CH_W:0] s_res;

        always_comb begin
            div_next = div_reg[i-1];
            h_res = div_bit(div_reg[i-1].h_rem, div_reg[i-1].h_num[rhc_pkg::HUE_W-1],
                            div_reg[i-1].h_div);
            s_res = div_bit(div_reg[i-1].s_rem, div_reg[i-1].s_num[rhc_pkg::SAT_W-1],
                            div_reg[i-1].value);
            div_next.h_rem = h_res[rhc_pkg::CH_W-1:0];
            div_next.h_num = {div_reg[i-1].h_num[rhc_pkg::HUE_W-2:0], h_res[rhc_pkg::CH_W]};
            if (i > SAT_START) begin
                div_next.s_rem = s_res[rhc_pkg::CH_W-1:0];
                div_next.s_num = {div_reg[i-1].s_num[rhc_pkg::SAT_W-2:0],
                                  s_res[rhc_pkg::CH_W]};
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[FRONT_STAGES-1+i]) begin
                div_reg[i] <= div_next;
            end
        end
    end

    // Result: grey pixels have hue 0, black pixels saturation 0, and a
    // quotient that overflows its field is clamped to all ones.
    always_comb begin
        priority if (div_reg[rhc_pkg::HUE_W].h_zero) begin
            m_data.hue = '0;
        end else if (div_reg[rhc_pkg::HUE_W].h_ovf) begin
            m_data.hue = '1;
        end else begin
            m_data.hue = div_reg[rhc_pkg::HUE_W].h_num;
        end
        priority if (div_reg[rhc_pkg::HUE_W].s_zero) begin
            m_data.saturation = '0;
        end else if (div_reg[rhc_pkg::HUE_W].s_ovf) begin
            m_data.saturation = '1;
        end else begin
            m_data.saturation = div_reg[rhc_pkg::HUE_W].s_num;
        end
        m_data.brightness = div_reg[rhc_pkg::HUE_W].value;
    end

    // An empty output stage means every stage can advance.
    a_ready_when_out_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready
    ) else $error("s_ready low while the output stage is empty");

    // Hue stays below one full turn.
    a_hue_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hue < rhc_pkg::HUE_W'(360 << rhc_pkg::HUE_FRAC_BITS))
    ) else $error("hue at or above 360 degrees");

    // A black pixel has neither hue nor saturation.
    a_black_pixel: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.brightness == '0) |-> (m_data.hue == '0 && m_data.saturation == '0)
    ) else $error("black pixel with nonzero hue or saturation");

endmodule
